// File: design/dns_response_address_picker_assert.svh
// assertion macros shared by the dns response address picker modules
// each macro expects signals named clock and reset in the calling module
`ifndef DNS_RESPONSE_ADDRESS_PICKER_ASSERT_SVH
`define DNS_RESPONSE_ADDRESS_PICKER_ASSERT_SVH

// same-cycle implication
`define DNSAP_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DNSAP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/dnsap_pkg.sv
// shared types and codes for the dns response address picker
// no dependencies
package dnsap_pkg;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_BYTE   = 2'd2;

   typedef logic [2:0] status_type;

   localparam status_type ST_FOUND     = 3'd0;
   localparam status_type ST_NO_MATCH  = 3'd1;
   localparam status_type ST_SERVER    = 3'd2;
   localparam status_type ST_QUESTIONS = 3'd3;
   localparam status_type ST_ANSWERS   = 3'd4;
   localparam status_type ST_TRUNCATED = 3'd5;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic       last;
   } dnsap_item_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] address;
      logic [3:0]  answer_number;
      logic [3:0]  response_code;
   } dnsap_result_type;

endpackage

// File: design/dns_response_address_picker.sv
// dns response address picker: picks the address of the answer whose question matches
// an accepted item passes the input register, then its result the result register
// throughput: one item per cycle; only a result stalled downstream holds a last byte back
// reset: synchronous; clears parse state and stored name length, name bytes undefined
// depends on dnsap_pkg, dnsap_parser and dns_response_address_picker_assert.svh
`include "dns_response_address_picker_assert.svh"

module dns_response_address_picker
   import dnsap_pkg::*;
#(
   parameter int MAX_QUESTIONS = 16,
   parameter int NAME_DEPTH    = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_address,
   output logic [3:0]  rsp_answer_number,
   output logic [3:0]  rsp_response_code
);

   logic             in_valid_ff, in_valid_in;
   dnsap_item_type   in_item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   dnsap_result_type rsp_result_ff;

   logic             accept;
   logic             out_free;
   logic             emits;
   logic             fire;
   logic             result_valid;
   dnsap_result_type result;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emits     = (in_item_ff.command == CMD_BYTE) && in_item_ff.last;
   assign fire      = in_valid_ff && (!emits || out_free);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !fire);
   assign rsp_valid_in = result_valid || (rsp_valid_ff && rsp_stall);

   dnsap_parser #(
      .MAX_QUESTIONS(MAX_QUESTIONS),
      .NAME_DEPTH   (NAME_DEPTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (in_item_ff),
      .result_valid(result_valid),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.command   <= req_command;
         in_item_ff.data_byte <= req_data_byte;
         in_item_ff.last      <= req_last;
      end
      if (result_valid) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_result_ff.status;
   assign rsp_address       = rsp_result_ff.address;
   assign rsp_answer_number = rsp_result_ff.answer_number;
   assign rsp_response_code = rsp_result_ff.response_code;

   `DNSAP_ASSERT_HOLDS(a_stall_needs_item, req_stall, in_valid_ff, "input stalled with empty input register")
   `DNSAP_ASSERT_NEXT(a_last_gives_result, fire && emits, rsp_valid, "last byte processed without result")
   `DNSAP_ASSERT_HOLDS(a_miss_is_zero, rsp_valid && (rsp_status != ST_FOUND), (rsp_address == '0) && (rsp_answer_number == '0), "address or index set without a found status")

endmodule

// File: design/dnsap_parser.sv
// response parser: stored query name, header and question walk, answer pick
// depends on dnsap_pkg and dns_response_address_picker_assert.svh
`include "dns_response_address_picker_assert.svh"

module dnsap_parser
   import dnsap_pkg::*;
#(
   parameter int MAX_QUESTIONS = 16,
   parameter int NAME_DEPTH    = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  dnsap_item_type   item,
   output logic             result_valid,
   output dnsap_result_type result
);

   localparam int AW = $clog2(NAME_DEPTH);
   localparam int LW = $clog2(NAME_DEPTH + 1);
   localparam int QW = $clog2(MAX_QUESTIONS + 1);

   localparam logic [LW-1:0]            NAME_FULL   = LW'(NAME_DEPTH);
   localparam logic [15:0]              COUNT_LIMIT = 16'(MAX_QUESTIONS);
   localparam logic [MAX_QUESTIONS-1:0] FLAG_ONE    = MAX_QUESTIONS'(1);
   localparam logic [3:0]               HDR_LAST    = 4'd11;
   localparam logic [3:0]               HDR_DONE    = 4'd12;
   localparam logic [3:0]               REC_LAST    = 4'd15;
   localparam logic [3:0]               REC_ADDR    = 4'd12;
   localparam logic [1:0]               TAIL_LAST   = 2'd3;
   localparam logic [3:0]               RCODE_MASK  = 4'hf;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_QLEN,
      PH_QLABEL,
      PH_QTAIL,
      PH_ANSWER,
      PH_DONE
   } phase_type;

   logic [7:0] name_mem [NAME_DEPTH];
   logic [7:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   phase_type              phase_ff, phase_in;
   logic [LW-1:0]          name_length_ff, name_length_in;
   logic [3:0]             header_count_ff, header_count_in;
   logic [3:0]             code_seen_ff, code_seen_in;
   logic [15:0]            question_total_ff, question_total_in;
   logic [15:0]            answer_total_ff, answer_total_in;
   logic [QW-1:0]          question_index_ff, question_index_in;
   logic [LW-1:0]          name_offset_ff, name_offset_in;
   logic [7:0]             label_left_ff, label_left_in;
   logic                   running_match_ff, running_match_in;
   logic [MAX_QUESTIONS-1:0] match_flags_ff, match_flags_in;
   logic [1:0]             tail_count_ff, tail_count_in;
   logic [QW-1:0]          answer_index_ff, answer_index_in;
   logic [3:0]             record_byte_ff, record_byte_in;
   logic                   found_flag_ff, found_flag_in;
   logic [31:0]            found_address_ff, found_address_in;
   logic [3:0]             found_index_ff, found_index_in;
   status_type             error_seen_ff, error_seen_in;

   logic [MAX_QUESTIONS-1:0] flag_shift;
   logic                     wanted;
   logic                     in_question;
   status_type               status;

   // read data always lines up with the current name offset: the address is the
   // offset that the next item will see
   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[wr_addr] <= item.data_byte;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= item.data_byte;
      end else begin
         rd_data_ff <= name_mem[rd_addr];
      end
   end

   assign rd_addr = reset ? '0 : name_offset_in[AW-1:0];
   assign wr_addr = name_length_ff[AW-1:0];

   assign flag_shift  = match_flags_ff >> answer_index_ff;
   assign wanted      = flag_shift[0];
   assign in_question = (phase_ff == PH_QLEN) || (phase_ff == PH_QLABEL) ||
                        (phase_ff == PH_QTAIL);

   always_comb begin
      phase_in          = phase_ff;
      name_length_in    = name_length_ff;
      header_count_in   = header_count_ff;
      code_seen_in      = code_seen_ff;
      question_total_in = question_total_ff;
      answer_total_in   = answer_total_ff;
      question_index_in = question_index_ff;
      name_offset_in    = name_offset_ff;
      label_left_in     = label_left_ff;
      running_match_in  = running_match_ff;
      match_flags_in    = match_flags_ff;
      tail_count_in     = tail_count_ff;
      answer_index_in   = answer_index_ff;
      record_byte_in    = record_byte_ff;
      found_flag_in     = found_flag_ff;
      found_address_in  = found_address_ff;
      found_index_in    = found_index_ff;
      error_seen_in     = error_seen_ff;
      wr_en             = 1'b0;
      result_valid      = 1'b0;
      status            = ST_NO_MATCH;
      result            = '0;

      if (fire) begin
         unique case (item.command)
            CMD_CLEAR: begin
               name_length_in = '0;
            end
            CMD_APPEND: begin
               if (name_length_ff < NAME_FULL) begin
                  wr_en          = 1'b1;
                  name_length_in = name_length_ff + 1'b1;
               end
            end
            CMD_BYTE: begin
               // every question byte, tail included, is checked against the name up to the stored name length
               if (in_question && (name_offset_ff < name_length_ff)) begin
                  if (rd_data_ff != item.data_byte) begin
                     running_match_in = 1'b0;
                  end
                  name_offset_in = name_offset_ff + 1'b1;
               end

               unique case (phase_ff)
                  PH_HEADER: begin
                     case (header_count_ff)
                        4'd3: code_seen_in = item.data_byte[3:0] & RCODE_MASK;
                        4'd4: question_total_in[15:8] = item.data_byte;
                        4'd5: question_total_in[7:0] = item.data_byte;
                        4'd6: answer_total_in[15:8] = item.data_byte;
                        4'd7: answer_total_in[7:0] = item.data_byte;
                        default: ;
                     endcase
                     if (header_count_ff < HDR_LAST) begin
                        header_count_in = header_count_ff + 1'b1;
                     end else begin
                        header_count_in = HDR_DONE;
                        if (code_seen_in != '0) begin
                           error_seen_in = ST_SERVER;
                           phase_in      = PH_DONE;
                        end else if (question_total_in > COUNT_LIMIT) begin
                           error_seen_in = ST_QUESTIONS;
                           phase_in      = PH_DONE;
                        end else if (answer_total_in > COUNT_LIMIT) begin
                           error_seen_in = ST_ANSWERS;
                           phase_in      = PH_DONE;
                        end else if (question_total_in == '0) begin
                           phase_in = (answer_total_in == '0) ? PH_DONE : PH_ANSWER;
                        end else begin
                           phase_in = PH_QLEN;
                        end
                     end
                  end
                  PH_QLEN: begin
                     if (item.data_byte == '0) begin
                        tail_count_in = '0;
                        phase_in      = PH_QTAIL;
                     end else begin
                        label_left_in = item.data_byte;
                        phase_in      = PH_QLABEL;
                     end
                  end
                  PH_QLABEL: begin
                     label_left_in = label_left_ff - 1'b1;
                     if (label_left_in == '0) begin
                        phase_in = PH_QLEN;
                     end
                  end
                  PH_QTAIL: begin
                     if (tail_count_ff < TAIL_LAST) begin
                        tail_count_in = tail_count_ff + 1'b1;
                     end else begin
                        if (running_match_in && (name_offset_in >= name_length_ff)) begin
                           match_flags_in = match_flags_ff | (FLAG_ONE << question_index_ff);
                        end
                        question_index_in = question_index_ff + 1'b1;
                        name_offset_in    = '0;
                        running_match_in  = 1'b1;
                        tail_count_in     = '0;
                        if (16'(question_index_in) >= question_total_ff) begin
                           phase_in = (answer_total_ff == '0) ? PH_DONE : PH_ANSWER;
                        end else begin
                           phase_in = PH_QLEN;
                        end
                     end
                  end
                  PH_ANSWER: begin
                     // address sits in the last four bytes of each fixed record
                     if (wanted && (record_byte_ff >= REC_ADDR)) begin
                        found_address_in = {found_address_ff[23:0], item.data_byte};
                     end
                     if (record_byte_ff < REC_LAST) begin
                        record_byte_in = record_byte_ff + 1'b1;
                     end else begin
                        record_byte_in = '0;
                        if (wanted) begin
                           found_flag_in  = 1'b1;
                           found_index_in = 4'(answer_index_ff);
                           phase_in       = PH_DONE;
                        end else begin
                           found_address_in = '0;
                           answer_index_in  = answer_index_ff + 1'b1;
                           if (16'(answer_index_in) >= answer_total_ff) begin
                              phase_in = PH_DONE;
                           end
                        end
                     end
                  end
                  PH_DONE: ;
                  default: ;
               endcase

               if (item.last) begin
                  // error_seen of zero means no error
                  if (error_seen_in != '0) begin
                     status = error_seen_in;
                  end else if (phase_in == PH_DONE) begin
                     status = found_flag_in ? ST_FOUND : ST_NO_MATCH;
                  end else begin
                     status = ST_TRUNCATED;
                  end
                  result_valid         = 1'b1;
                  result.status        = status;
                  result.address       = (status == ST_FOUND) ? found_address_in : '0;
                  result.answer_number = (status == ST_FOUND) ? found_index_in : '0;
                  result.response_code = code_seen_in;

                  // per-packet state back to its start, stored name kept
                  phase_in          = PH_HEADER;
                  header_count_in   = '0;
                  code_seen_in      = '0;
                  question_total_in = '0;
                  answer_total_in   = '0;
                  question_index_in = '0;
                  name_offset_in    = '0;
                  label_left_in     = '0;
                  running_match_in  = 1'b1;
                  match_flags_in    = '0;
                  tail_count_in     = '0;
                  answer_index_in   = '0;
                  record_byte_in    = '0;
                  found_flag_in     = 1'b0;
                  found_address_in  = '0;
                  found_index_in    = '0;
                  error_seen_in     = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HEADER;
         name_length_ff    <= '0;
         header_count_ff   <= '0;
         code_seen_ff      <= '0;
         question_total_ff <= '0;
         answer_total_ff   <= '0;
         question_index_ff <= '0;
         name_offset_ff    <= '0;
         label_left_ff     <= '0;
         running_match_ff  <= 1'b1;
         match_flags_ff    <= '0;
         tail_count_ff     <= '0;
         answer_index_ff   <= '0;
         record_byte_ff    <= '0;
         found_flag_ff     <= 1'b0;
         found_address_ff  <= '0;
         found_index_ff    <= '0;
         error_seen_ff     <= '0;
      end else begin
         phase_ff          <= phase_in;
         name_length_ff    <= name_length_in;
         header_count_ff   <= header_count_in;
         code_seen_ff      <= code_seen_in;
         question_total_ff <= question_total_in;
         answer_total_ff   <= answer_total_in;
         question_index_ff <= question_index_in;
         name_offset_ff    <= name_offset_in;
         label_left_ff     <= label_left_in;
         running_match_ff  <= running_match_in;
         match_flags_ff    <= match_flags_in;
         tail_count_ff     <= tail_count_in;
         answer_index_ff   <= answer_index_in;
         record_byte_ff    <= record_byte_in;
         found_flag_ff     <= found_flag_in;
         found_address_ff  <= found_address_in;
         found_index_ff    <= found_index_in;
         error_seen_ff     <= error_seen_in;
      end
   end

   `DNSAP_ASSERT_HOLDS(a_header_closed, phase_ff != PH_HEADER, header_count_ff == HDR_DONE, "left header phase before last header byte")
   `DNSAP_ASSERT_HOLDS(a_question_range, in_question, 16'(question_index_ff) < question_total_ff, "question walk past question count")
   `DNSAP_ASSERT_HOLDS(a_found_done, found_flag_ff, phase_ff == PH_DONE, "answer found but parse still running")

endmodule

// File: test/dns_response_address_picker_tb.sv
// testbench for dns_response_address_picker: loads query names, streams responses byte by byte
// and checks every picked address against a parser model kept inside the bench
// depends on dnsap_pkg and the dns_response_address_picker design
module dns_response_address_picker_tb;
   import dnsap_pkg::*;

   localparam int QUESTION_LIMIT = 16;
   localparam int NAME_CAPACITY  = 256;
   localparam int QUIET_LIMIT    = 4000;
   localparam logic [1:0] CMD_IGNORED = 2'd3;

   typedef logic [7:0] octet_list [$];

   typedef enum logic [2:0] {
      WALK_HEADER, WALK_LABEL_LEN, WALK_LABEL, WALK_TAIL, WALK_ANSWER, WALK_DONE
   } walk_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_CLEAR;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_address;
   logic [3:0]  rsp_answer_number;
   logic [3:0]  rsp_response_code;

   dns_response_address_picker u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_address       (rsp_address),
      .rsp_answer_number (rsp_answer_number),
      .rsp_response_code (rsp_response_code)
   );

   // parser copy: stored name plus per-packet walk state
   logic [7:0]     qname_copy [NAME_CAPACITY];
   int unsigned    name_fill;
   walk_phase_type walk;
   int unsigned    hdr_pos;
   logic [3:0]     rcode;
   logic [15:0]    qd_count;
   logic [15:0]    an_count;
   int unsigned    q_pos;
   int unsigned    name_pos;
   logic [7:0]     label_rem;
   bit             name_ok;
   logic [63:0]    q_hits;
   int unsigned    tail_pos;
   int unsigned    a_pos;
   int unsigned    rec_pos;
   bit             have_addr;
   logic [31:0]    addr_acc;
   logic [3:0]     addr_slot;
   bit             err_flag;
   status_type     err_code;

   dnsap_result_type pending_picks [$];
   octet_list        current_name;
   int               picks_due;
   int               items_sent;
   int               failures;
   int               quiet_cycles;
   int               sender_idle_pct;
   int               receiver_stall_pct;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void clear_walk();
      walk      = WALK_HEADER;
      hdr_pos   = 0;
      rcode     = 4'h0;
      qd_count  = 16'h0;
      an_count  = 16'h0;
      q_pos     = 0;
      name_pos  = 0;
      label_rem = 8'h00;
      name_ok   = 1'b1;
      q_hits    = 64'h0;
      tail_pos  = 0;
      a_pos     = 0;
      rec_pos   = 0;
      have_addr = 1'b0;
      addr_acc  = 32'h0;
      addr_slot = 4'h0;
      err_flag  = 1'b0;
      err_code  = ST_FOUND;
   endfunction

   function automatic void enter_answers();
      walk = (an_count == 16'h0) ? WALK_DONE : WALK_ANSWER;
   endfunction

   function automatic void raise_error(input status_type code);
      err_flag = 1'b1;
      err_code = code;
      walk     = WALK_DONE;
   endfunction

   function automatic void walk_header(input logic [7:0] b);
      case (hdr_pos)
         3: rcode = b[3:0];
         4: qd_count[15:8] = b;
         5: qd_count[7:0] = b;
         6: an_count[15:8] = b;
         7: an_count[7:0] = b;
         default: ;
      endcase
      if (hdr_pos < 11) begin
         hdr_pos++;
      end else begin
         hdr_pos = 12;
         // response code first, then question count, then answer count
         if (rcode != 4'h0) raise_error(ST_SERVER);
         else if (qd_count > QUESTION_LIMIT) raise_error(ST_QUESTIONS);
         else if (an_count > QUESTION_LIMIT) raise_error(ST_ANSWERS);
         else if (qd_count == 16'h0) enter_answers();
         else walk = WALK_LABEL_LEN;
      end
   endfunction

   function automatic void compare_name(input logic [7:0] b);
      if (name_pos < name_fill && name_pos < NAME_CAPACITY) begin
         if (qname_copy[8'(name_pos)] != b) name_ok = 1'b0;
         name_pos++;
      end
   endfunction

   function automatic void close_question();
      if (name_ok && name_pos >= name_fill && q_pos < 64) q_hits[6'(q_pos)] = 1'b1;
      q_pos++;
      name_pos = 0;
      name_ok  = 1'b1;
      tail_pos = 0;
      if (q_pos >= qd_count) enter_answers();
      else walk = WALK_LABEL_LEN;
   endfunction

   function automatic void walk_answer(input logic [7:0] b);
      bit wanted;
      wanted = (a_pos < 64) && q_hits[6'(a_pos)];
      if (wanted && rec_pos >= 12) addr_acc = {addr_acc[23:0], b};
      if (rec_pos < 15) begin
         rec_pos++;
      end else begin
         rec_pos = 0;
         if (wanted) begin
            have_addr = 1'b1;
            addr_slot = a_pos[3:0];
            walk      = WALK_DONE;
         end else begin
            addr_acc = 32'h0;
            a_pos++;
            if (a_pos >= an_count) walk = WALK_DONE;
         end
      end
   endfunction

   function automatic void walk_byte(input logic [7:0] b);
      case (walk)
         WALK_HEADER: walk_header(b);
         WALK_LABEL_LEN: begin
            compare_name(b);
            if (b == 8'h00) begin
               tail_pos = 0;
               walk     = WALK_TAIL;
            end else begin
               // compression pointers count as plain lengths
               label_rem = b;
               walk      = WALK_LABEL;
            end
         end
         WALK_LABEL: begin
            compare_name(b);
            label_rem = label_rem - 8'd1;
            if (label_rem == 8'h00) walk = WALK_LABEL_LEN;
         end
         WALK_TAIL: begin
            compare_name(b);
            if (tail_pos < 3) tail_pos++;
            else close_question();
         end
         WALK_ANSWER: walk_answer(b);
         default: ;
      endcase
   endfunction

   // applies one item to the parser copy; returns 1 with the pick when a packet ends
   function automatic bit pick_for_item(input logic [1:0] cmd, input logic [7:0] b,
                                        input logic lst, output dnsap_result_type pick);
      status_type st;
      bit         produced;
      pick     = '0;
      produced = 1'b0;
      case (cmd)
         CMD_CLEAR: name_fill = 0;
         CMD_APPEND: begin
            if (name_fill < NAME_CAPACITY) begin
               qname_copy[8'(name_fill)] = b;
               name_fill++;
            end
         end
         CMD_BYTE: begin
            walk_byte(b);
            if (lst) begin
               if (err_flag) st = err_code;
               else if (walk == WALK_DONE) st = have_addr ? ST_FOUND : ST_NO_MATCH;
               else st = ST_TRUNCATED;
               pick.status        = st;
               pick.address       = (st == ST_FOUND) ? addr_acc : 32'h0;
               pick.answer_number = (st == ST_FOUND) ? addr_slot : 4'h0;
               pick.response_code = rcode;
               clear_walk();
               produced = 1'b1;
            end
         end
         default: ;
      endcase
      return produced;
   endfunction

   function automatic void log_failure(input string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) log_failure($sformatf("%s expected %h, got %h", what, want_v, got_v));
   endfunction

   always @(posedge clock) begin : result_check
      dnsap_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_picks.size() == 0) begin
            log_failure($sformatf("result with none pending: status %0d address %h",
                                  rsp_status, rsp_address));
         end else begin
            want = pending_picks.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("address", want.address, rsp_address);
            check_field("answer_number", 32'(want.answer_number), 32'(rsp_answer_number));
            check_field("response_code", 32'(want.response_code), 32'(rsp_response_code));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("dns_response_address_picker_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < receiver_stall_pct);
   end

   // called right after a rising edge; returns at the edge that takes the item
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] b, input logic lst);
      dnsap_result_type pick;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= b;
      req_last      <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (pick_for_item(cmd, b, lst, pick)) begin
         pending_picks.push_back(pick);
         picks_due++;
      end
      if (cmd != CMD_IGNORED) items_sent++;
   endtask

   task automatic send_bytes(input octet_list pkt, input int start_at, input int upto,
                             input bit mark_last);
      for (int i = start_at; i < upto; i++) begin
         if ($urandom_range(99) < 3)
            send_item(CMD_IGNORED, 8'($urandom_range(255)), 1'($urandom_range(1)));
         send_item(CMD_BYTE, pkt[i], mark_last && (i == upto - 1));
      end
   endtask

   task automatic load_name(input octet_list nm);
      send_item(CMD_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
      foreach (nm[i]) send_item(CMD_APPEND, nm[i], 1'($urandom_range(1)));
      current_name = nm;
   endtask

   function automatic octet_list random_qname();
      octet_list nm;
      int        len;
      repeat ($urandom_range(3, 1)) begin
         len = $urandom_range(6, 1);
         nm.push_back(8'(len));
         repeat (len) nm.push_back(8'($urandom_range(255)));
      end
      nm.push_back(8'h00);
      return nm;
   endfunction

   // same label layout, one content byte changed
   function automatic octet_list near_miss(input octet_list nm);
      int pos;
      if (nm.size() < 2 || nm[0] == 8'h00) return random_qname();
      pos = $urandom_range(nm[0], 1);
      nm[pos] = nm[pos] ^ 8'($urandom_range(255, 1));
      return nm;
   endfunction

   function automatic octet_list with_tail(input octet_list nm);
      repeat (4) nm.push_back(8'($urandom_range(255)));
      return nm;
   endfunction

   function automatic octet_list make_header(input logic [3:0] rc, input logic [15:0] qd,
                                             input logic [15:0] an);
      octet_list h;
      repeat (3) h.push_back(8'($urandom_range(255)));
      h.push_back({4'($urandom_range(15)), rc});
      h.push_back(qd[15:8]);
      h.push_back(qd[7:0]);
      h.push_back(an[15:8]);
      h.push_back(an[7:0]);
      repeat (4) h.push_back(8'($urandom_range(255)));
      return h;
   endfunction

   function automatic void add_question(ref octet_list pkt, input octet_list nm);
      octet_list q;
      q = with_tail(nm);
      foreach (q[i]) pkt.push_back(q[i]);
   endfunction

   function automatic void add_answer(ref octet_list pkt, input logic [31:0] addr);
      repeat (12) pkt.push_back(8'($urandom_range(255)));
      pkt.push_back(addr[31:24]);
      pkt.push_back(addr[23:16]);
      pkt.push_back(addr[15:8]);
      pkt.push_back(addr[7:0]);
   endfunction

   // question bytes come complete with their tail
   function automatic octet_list one_question_response(input octet_list qbytes,
                                                       input logic [31:0] addr);
      octet_list pkt;
      pkt = make_header(4'h0, 16'd1, 16'd1);
      foreach (qbytes[i]) pkt.push_back(qbytes[i]);
      add_answer(pkt, addr);
      return pkt;
   endfunction

   function automatic logic [31:0] random_address();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return 32'h0;
      if (roll == 1) return 32'hffff_ffff;
      return $urandom();
   endfunction

   function automatic int random_count();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return 0;
      if (roll < 70) return $urandom_range(3, 1);
      if (roll < 85) return $urandom_range(QUESTION_LIMIT - 1, 4);
      if (roll < 93) return QUESTION_LIMIT;
      if (roll < 97) return QUESTION_LIMIT + 1;
      return $urandom_range(65535, QUESTION_LIMIT + 2);
   endfunction

   function automatic octet_list question_name(input bit hit);
      // an empty stored name matches any question
      if (current_name.size() == 0) return random_qname();
      if (hit) return current_name;
      if ($urandom_range(1)) return near_miss(current_name);
      return random_qname();
   endfunction

   task automatic test_name_commands();
      octet_list nm;
      octet_list pkt;
      nm = '{8'h03, 8'h77, 8'h77, 8'h77, 8'h02, 8'h61, 8'h62, 8'h00};
      send_item(CMD_IGNORED, 8'hff, 1'b1);
      send_item(CMD_APPEND, 8'hff, 1'b1);
      load_name(nm);
      pkt = one_question_response(with_tail(nm), 32'h0000_0000);
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      pkt = one_question_response(with_tail(nm), 32'hffff_ffff);
      send_bytes(pkt, 0, pkt.size(), 1'b1);
   endtask

   task automatic test_first_match();
      octet_list pkt;
      pkt = make_header(4'h0, 16'd2, 16'd3);
      add_question(pkt, near_miss(current_name));
      add_question(pkt, current_name);
      add_answer(pkt, 32'h0102_0304);
      add_answer(pkt, 32'hffff_ffff);
      add_answer(pkt, 32'h0000_0000);
      // bytes after the chosen record are ignored
      repeat (3) pkt.push_back(8'($urandom_range(255)));
      send_bytes(pkt, 0, pkt.size(), 1'b1);
   endtask

   task automatic test_header_errors();
      octet_list pkt;
      pkt = make_header(4'hf, 16'hffff, 16'hffff);
      add_answer(pkt, random_address());
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      pkt = make_header(4'h1, 16'd1, 16'd1);
      add_question(pkt, current_name);
      add_answer(pkt, random_address());
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      pkt = make_header(4'h0, 16'd17, 16'hffff);
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      pkt = make_header(4'h0, 16'h0100, 16'h0000);
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      pkt = make_header(4'h0, 16'd16, 16'd17);
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      pkt = make_header(4'h0, 16'h0000, 16'h8000);
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      // no questions and no answers completes with no match
      pkt = make_header(4'h0, 16'd0, 16'd0);
      pkt.push_back(8'hff);
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      // answers with no question behind them never match
      pkt = make_header(4'h0, 16'd0, 16'd2);
      add_answer(pkt, random_address());
      add_answer(pkt, random_address());
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      pkt = make_header(4'h0, 16'd1, 16'd3);
      add_question(pkt, near_miss(current_name));
      repeat (3) add_answer(pkt, random_address());
      send_bytes(pkt, 0, pkt.size(), 1'b1);
   endtask

   task automatic test_truncation();
      octet_list full;
      int        cuts [$];
      full = make_header(4'h0, 16'd1, 16'd1);
      add_question(full, current_name);
      add_answer(full, 32'hc0a8_0001);
      cuts = '{1, 3, 5, 12, 13, 12 + current_name.size() + 2, full.size() - 1, full.size()};
      foreach (cuts[i]) send_bytes(full, 0, cuts[i], 1'b1);
      // response code seen but header never finished
      full = make_header(4'h5, 16'd1, 16'd1);
      send_bytes(full, 0, 8, 1'b1);
   endtask

   task automatic test_name_rules();
      octet_list nm;
      octet_list q;
      octet_list pkt;
      octet_list base;
      octet_list tail4;
      int        split;
      load_name(nm);
      pkt = one_question_response(with_tail(random_qname()), random_address());
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      // stored name running into the question tail
      base  = '{8'h02, 8'h68, 8'h69, 8'h00};
      tail4 = with_tail(nm);
      q = base;
      foreach (tail4[i]) q.push_back(tail4[i]);
      load_name(q);
      pkt = one_question_response(q, random_address());
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      nm = q;
      nm.push_back(8'h55);
      load_name(nm);
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      nm = '{8'h02, 8'h68};
      load_name(nm);
      pkt = one_question_response(with_tail(base), random_address());
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      // compression pointer byte walked as a 192-byte label
      nm = '{8'hc0, 8'h0c};
      load_name(nm);
      q = nm;
      repeat (191) q.push_back(8'($urandom_range(255)));
      q.push_back(8'h00);
      pkt = one_question_response(with_tail(q), random_address());
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      // name replaced in the middle of a question
      nm = '{8'h03, 8'h61, 8'h62, 8'h63, 8'h00};
      pkt = one_question_response(with_tail(nm), random_address());
      split = 14;
      load_name(nm);
      send_bytes(pkt, 0, split, 1'b0);
      send_item(CMD_CLEAR, 8'h00, 1'b1);
      send_item(CMD_APPEND, 8'h03, 1'b0);
      send_item(CMD_APPEND, 8'h61, 1'b0);
      send_item(CMD_APPEND, 8'h78, 1'b1);
      send_bytes(pkt, split, pkt.size(), 1'b1);
      load_name(nm);
      send_bytes(pkt, 0, split, 1'b0);
      send_item(CMD_CLEAR, 8'hff, 1'b0);
      send_bytes(pkt, split, pkt.size(), 1'b1);
   endtask

   task automatic test_full_store();
      octet_list nm;
      octet_list q;
      octet_list pkt;
      repeat (4) begin
         nm.push_back(8'd63);
         repeat (63) nm.push_back(8'($urandom_range(255)));
      end
      load_name(nm);
      // appends past a full store are dropped
      repeat (4) send_item(CMD_APPEND, 8'hff, 1'b0);
      q = nm;
      q.push_back(8'h00);
      pkt = one_question_response(with_tail(q), random_address());
      send_bytes(pkt, 0, pkt.size(), 1'b1);
      q[255] = q[255] ^ 8'h01;
      pkt = one_question_response(with_tail(q), random_address());
      send_bytes(pkt, 0, pkt.size(), 1'b1);
   endtask

   task automatic test_last_slot();
      octet_list nm;
      octet_list pkt;
      nm = '{8'h01, 8'h5a, 8'h00};
      load_name(nm);
      pkt = make_header(4'h0, 16'd16, 16'd16);
      repeat (15) add_question(pkt, near_miss(nm));
      add_question(pkt, nm);
      repeat (15) add_answer(pkt, random_address());
      add_answer(pkt, 32'ha5a5_5a5a);
      send_bytes(pkt, 0, pkt.size(), 1'b1);
   endtask

   task automatic random_response();
      octet_list pkt;
      octet_list nm;
      int        qd;
      int        an;
      int        upto;
      logic [3:0] rc;
      if ($urandom_range(99) < 15) begin
         if ($urandom_range(9) != 0) nm = random_qname();
         load_name(nm);
      end
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(40, 1)) pkt.push_back(8'($urandom_range(255)));
      end else begin
         rc  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 1)) : 4'h0;
         qd  = random_count();
         an  = random_count();
         pkt = make_header(rc, 16'(qd), 16'(an));
         if (qd <= QUESTION_LIMIT && an <= QUESTION_LIMIT) begin
            for (int i = 0; i < qd; i++) add_question(pkt, question_name($urandom_range(99) < 40));
            for (int i = 0; i < an; i++) add_answer(pkt, random_address());
         end
         if ($urandom_range(99) < 20) repeat ($urandom_range(8, 1))
            pkt.push_back(8'($urandom_range(255)));
      end
      upto = pkt.size();
      if (upto > 1 && $urandom_range(99) < 12) upto = $urandom_range(upto - 1, 1);
      send_bytes(pkt, 0, upto, 1'b1);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      int items_at_start;
      int picks_at_start;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      items_at_start     = items_sent;
      picks_at_start     = picks_due;
      load_name(random_qname());
      while (items_sent - items_at_start < 115 || picks_due - picks_at_start < 12)
         random_response();
   endtask

   initial begin
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      picks_due          = 0;
      items_sent         = 0;
      failures           = 0;
      quiet_cycles       = 0;
      name_fill          = 0;
      clear_walk();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_name_commands();
      test_first_match();
      test_header_errors();
      test_truncation();
      test_name_rules();
      test_full_store();
      test_last_slot();
      test_random_traffic(0, 0);
      test_random_traffic(50, 0);
      test_random_traffic(0, 50);
      test_random_traffic(30, 30);
      req_valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("dns_response_address_picker_tb: done, clean");
      end else begin
         $display("dns_response_address_picker_tb: done, errors");
      end
      $finish;
   end

endmodule

// File: dns_response_address_picker.f
+incdir+design
design/dnsap_pkg.sv
design/dnsap_parser.sv
design/dns_response_address_picker.sv
test/dns_response_address_picker_tb.sv
